[hdl/vpid_pkg.sv]
package vpid_pkg;

   // request codes on req_type
   localparam logic [1:0] REQ_RATE  = 2'd0;
   localparam logic [1:0] REQ_TICKS = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // register map
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 47;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_LOW  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_HIGH = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_INT_BOUND  = 3'd5;

   // register reset values
   localparam logic signed [31:0] GAIN_RESET       = 32'sd0;
   localparam logic signed [31:0] DRIVE_LOW_RESET  = -32'sd65536;
   localparam logic signed [31:0] DRIVE_HIGH_RESET = 32'sd65536;
   localparam logic [46:0]        INT_BOUND_RESET  = 47'd6553600;

   // scale factors: ticks to Q24.8 per second, and microseconds per second
   localparam logic signed [31:0] TICK_SCALE = 32'sd256000000;
   localparam logic signed [31:0] US_PER_SEC = 32'sd1000000;
   localparam logic [19:0]        US_DIVISOR = 20'd1000000;

   // sequencer step counts
   localparam logic [4:0] MUL_LAST = 5'd4;   // load + four 16 bit partial products
   localparam logic [4:0] DIV_LAST = 5'd30;  // load + 29 radix-4 steps + sign fix

   typedef logic signed [32:0] err_type;
   typedef logic signed [47:0] integ_type;
   typedef logic signed [95:0] wide_type;

endpackage

[hdl/velocity_pid_controller.sv]
// velocity_pid_controller: fixed-point velocity PID step, one result per transaction
//
// req_* : one transaction carries a request code, a measured rate or a tick count, the
//         target rate and the period in microseconds; accepted on req_valid & req_ready
// rsp_* : clamped drive (Q16.16) and ok flag, one transaction for every request
// csr_* : write-only register port; write only while the block is idle (not enforced)
//
// one shared 32x17 multiplier and one radix-4 restoring divider run under a
// sequencer; the divider passes dominate a transaction's run time, and req_ready is
// high only in the idle state, so the block takes a new request only after the last
// one has left the sequencer; a clear, a zero period or an unused code is answered
// straight from the decode step
// the result sits in an output register, so the next transaction is taken while a
// result still waits; a stalled receiver holds the sequencer only at its final step
//
// reset (synchronous, active high) restores register defaults, zeroes the integral
// and previous error, and empties the output register
module velocity_pid_controller
   import vpid_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_type,
   input  logic signed [31:0]     req_measured_rate,
   input  logic signed [15:0]     req_tick_count,
   input  logic signed [31:0]     req_target_rate,
   input  logic [15:0]            req_period_us,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_drive,
   output logic                   rsp_ok,
   // register write port
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_TICK_MUL,
      ST_TICK_DIV,
      ST_MEAS,
      ST_ERR,
      ST_INC_MUL,
      ST_INC_DIV,
      ST_INTEG_ADD,
      ST_INTEG_CLAMP,
      ST_DER_MUL,
      ST_DER_DIV,
      ST_P_MUL,
      ST_I_MUL,
      ST_D_MUL,
      ST_SUM,
      ST_CLAMP
   } state_type;

   state_type state_ff;
   logic [4:0] cnt_ff;

   // configuration registers
   logic signed [31:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [31:0] lim_a_ff, lim_b_ff;
   logic [46:0]        bound_ff;

   // captured transaction
   logic [1:0]         req_code_ff;
   logic signed [31:0] meas_in_ff;
   logic signed [15:0] tick_ff;
   logic signed [31:0] target_ff;
   logic [15:0]        dt_ff;

   // controller state and intermediates
   integ_type          integral_ff;
   err_type            last_err_ff;
   err_type            err_ff;
   logic signed [31:0] meas_ff;
   logic signed [48:0] isum_ff;
   wide_type           sum_ff;

   // shared multiplier
   logic [63:0]        mb_ff;
   wide_type           acc_ff;
   logic signed [31:0] mul_a;
   logic signed [16:0] mul_chunk;
   logic signed [48:0] mul_prod;
   wide_type           acc_in;
   logic [63:0]        mb_load;
   logic               mul_active;
   state_type          mul_next;

   // shared divider
   logic [57:0]        dq_ff;
   logic [19:0]        rem_ff;
   logic               neg_ff;
   logic signed [58:0] quo_ff;
   logic [19:0]        dsor;
   logic [57:0]        dq_in;
   logic [19:0]        rem_in;
   logic [57:0]        acc_mag;
   logic               div_active;
   state_type          div_next;

   // output register
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_drive_ff;
   logic               rsp_ok_ff;

   logic               out_free;
   logic               rsp_load;
   logic signed [31:0] meas_sat;
   logic signed [48:0] bound_pos;
   logic signed [31:0] lim_lo, lim_hi;
   wide_type           lim_lo_w, lim_hi_w;
   logic signed [33:0] err_diff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;
   assign rsp_ok    = rsp_ok_ff;

   // a new response enters the output register at this edge
   assign rsp_load = out_free && (state_ff == ST_CLAMP ||
                     (state_ff == ST_DECODE &&
                      !(dt_ff != 16'd0 &&
                        (req_code_ff == REQ_RATE || req_code_ff == REQ_TICKS))));

   // operand and successor selection for the shared multiplier
   always_comb begin
      mul_active = 1'b1;
      mul_a      = 32'sd0;
      mb_load    = 64'd0;
      mul_next   = ST_IDLE;
      err_diff   = 34'(err_ff) - 34'(last_err_ff);
      case (state_ff)
         ST_TICK_MUL: begin
            mul_a    = TICK_SCALE;
            mb_load  = 64'(tick_ff);
            mul_next = ST_TICK_DIV;
         end
         ST_INC_MUL: begin
            mul_a    = $signed({8'd0, dt_ff, 8'd0});
            mb_load  = 64'(err_ff);
            mul_next = ST_INC_DIV;
         end
         ST_DER_MUL: begin
            mul_a    = US_PER_SEC;
            mb_load  = 64'(err_diff);
            mul_next = ST_DER_DIV;
         end
         ST_P_MUL: begin
            mul_a    = gain_p_ff;
            mb_load  = 64'(err_ff);
            mul_next = ST_I_MUL;
         end
         ST_I_MUL: begin
            mul_a    = gain_i_ff;
            mb_load  = 64'(integral_ff);
            mul_next = ST_D_MUL;
         end
         ST_D_MUL: begin
            mul_a    = gain_d_ff;
            mb_load  = 64'(quo_ff);
            mul_next = ST_SUM;
         end
         default: begin
            mul_active = 1'b0;
         end
      endcase
   end

   // signed top chunk first, then unsigned chunks; the accumulator shifts up 16 each step
   always_comb begin
      mul_chunk = (cnt_ff == 5'd1) ? $signed({mb_ff[63], mb_ff[63:48]})
                                   : $signed({1'b0, mb_ff[63:48]});
      mul_prod  = mul_a * mul_chunk;
      acc_in    = (acc_ff <<< 16) + 96'(mul_prod);
   end

   // divisor and successor selection for the shared divider
   always_comb begin
      div_active = 1'b1;
      dsor       = {4'd0, dt_ff};
      div_next   = ST_IDLE;
      case (state_ff)
         ST_TICK_DIV: div_next = ST_MEAS;
         ST_INC_DIV: begin
            dsor     = US_DIVISOR;
            div_next = ST_INTEG_ADD;
         end
         ST_DER_DIV: div_next = ST_P_MUL;
         default:    div_active = 1'b0;
      endcase
   end

   // two restoring quotient bits per cycle on the magnitude
   always_comb begin
      logic [20:0] t1, t2;
      logic [19:0] r1;
      logic        ge1, ge2;
      logic [57:0] dq1;
      t1     = {rem_ff, dq_ff[57]};
      ge1    = t1 >= {1'b0, dsor};
      r1     = ge1 ? 20'(t1 - {1'b0, dsor}) : t1[19:0];
      dq1    = {dq_ff[56:0], ge1};
      t2     = {r1, dq1[57]};
      ge2    = t2 >= {1'b0, dsor};
      rem_in = ge2 ? 20'(t2 - {1'b0, dsor}) : t2[19:0];
      dq_in  = {dq1[56:0], ge2};
      acc_mag = acc_ff[95] ? (58'd0 - acc_ff[57:0]) : acc_ff[57:0];
   end

   // rate saturation, integral bound and output limits in either order
   always_comb begin
      if (quo_ff > $signed({27'd0, 32'h7FFF_FFFF})) begin
         meas_sat = 32'sh7FFF_FFFF;
      end else if (quo_ff < $signed({{27{1'b1}}, 32'h8000_0000})) begin
         meas_sat = 32'sh8000_0000;
      end else begin
         meas_sat = quo_ff[31:0];
      end
      bound_pos = $signed({2'b00, bound_ff});
      lim_lo    = (lim_a_ff < lim_b_ff) ? lim_a_ff : lim_b_ff;
      lim_hi    = (lim_a_ff < lim_b_ff) ? lim_b_ff : lim_a_ff;
      lim_lo_w  = 96'(lim_lo);
      lim_hi_w  = 96'(lim_hi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 5'd0;
         gain_p_ff    <= GAIN_RESET;
         gain_i_ff    <= GAIN_RESET;
         gain_d_ff    <= GAIN_RESET;
         lim_a_ff     <= DRIVE_LOW_RESET;
         lim_b_ff     <= DRIVE_HIGH_RESET;
         bound_ff     <= INT_BOUND_RESET;
         integral_ff  <= '0;
         last_err_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GAIN_P:     gain_p_ff <= csr_wdata[31:0];
               CSR_GAIN_I:     gain_i_ff <= csr_wdata[31:0];
               CSR_GAIN_D:     gain_d_ff <= csr_wdata[31:0];
               CSR_DRIVE_LOW:  lim_a_ff  <= csr_wdata[31:0];
               CSR_DRIVE_HIGH: lim_b_ff  <= csr_wdata[31:0];
               CSR_INT_BOUND:  bound_ff  <= csr_wdata;
               default: ;
            endcase
         end

         // response taken by the receiver, unless a new one is loaded at the same edge
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         if (mul_active) begin
            if (cnt_ff == 5'd0) begin
               mb_ff  <= mb_load;
               acc_ff <= '0;
               // previous product is still in the accumulator here
               if (state_ff == ST_I_MUL) begin
                  sum_ff <= acc_ff >>> 8;
               end
               if (state_ff == ST_D_MUL) begin
                  sum_ff <= sum_ff + (acc_ff >>> 16);
               end
               if (state_ff == ST_DER_MUL) begin
                  last_err_ff <= err_ff;
               end
            end else begin
               mb_ff  <= {mb_ff[47:0], 16'd0};
               acc_ff <= acc_in;
            end
            if (cnt_ff == MUL_LAST) begin
               cnt_ff   <= 5'd0;
               state_ff <= mul_next;
            end else begin
               cnt_ff <= cnt_ff + 5'd1;
            end
         end else if (div_active) begin
            if (cnt_ff == 5'd0) begin
               dq_ff  <= acc_mag;
               rem_ff <= 20'd0;
               neg_ff <= acc_ff[95];
            end else if (cnt_ff == DIV_LAST) begin
               quo_ff <= neg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
            end else begin
               dq_ff  <= dq_in;
               rem_ff <= rem_in;
            end
            if (cnt_ff == DIV_LAST) begin
               cnt_ff   <= 5'd0;
               state_ff <= div_next;
            end else begin
               cnt_ff <= cnt_ff + 5'd1;
            end
         end else begin
            case (state_ff)
               ST_IDLE: begin
                  if (req_valid) begin
                     req_code_ff <= req_type;
                     meas_in_ff  <= req_measured_rate;
                     tick_ff     <= req_tick_count;
                     target_ff   <= req_target_rate;
                     dt_ff       <= req_period_us;
                     cnt_ff      <= 5'd0;
                     state_ff    <= ST_DECODE;
                  end
               end
               ST_DECODE: begin
                  if (req_code_ff == REQ_CLEAR) begin
                     if (out_free) begin
                        integral_ff  <= '0;
                        last_err_ff  <= '0;
                        rsp_drive_ff <= 32'sd0;
                        rsp_ok_ff    <= 1'b1;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end
                  end else if (dt_ff != 16'd0 && req_code_ff == REQ_RATE) begin
                     meas_ff  <= meas_in_ff;
                     state_ff <= ST_ERR;
                  end else if (dt_ff != 16'd0 && req_code_ff == REQ_TICKS) begin
                     state_ff <= ST_TICK_MUL;
                  end else if (out_free) begin
                     // zero period or unused code: no state change
                     rsp_drive_ff <= 32'sd0;
                     rsp_ok_ff    <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               end
               ST_MEAS: begin
                  meas_ff  <= meas_sat;
                  state_ff <= ST_ERR;
               end
               ST_ERR: begin
                  err_ff   <= 33'(target_ff) - 33'(meas_ff);
                  state_ff <= ST_INC_MUL;
               end
               ST_INTEG_ADD: begin
                  isum_ff  <= 49'(integral_ff) + quo_ff[48:0];
                  state_ff <= ST_INTEG_CLAMP;
               end
               ST_INTEG_CLAMP: begin
                  if (isum_ff > bound_pos) begin
                     integral_ff <= bound_pos[47:0];
                  end else if (isum_ff < -bound_pos) begin
                     integral_ff <= 48'(-bound_pos);
                  end else begin
                     integral_ff <= isum_ff[47:0];
                  end
                  state_ff <= ST_DER_MUL;
               end
               ST_SUM: begin
                  sum_ff   <= sum_ff + (acc_ff >>> 8);
                  state_ff <= ST_CLAMP;
               end
               ST_CLAMP: begin
                  if (out_free) begin
                     if (sum_ff < lim_lo_w) begin
                        rsp_drive_ff <= lim_lo;
                     end else if (sum_ff > lim_hi_w) begin
                        rsp_drive_ff <= lim_hi;
                     end else begin
                        rsp_drive_ff <= sum_ff[31:0];
                     end
                     rsp_ok_ff    <= 1'b1;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               end
               default: begin
                  state_ff <= ST_IDLE;
               end
            endcase
         end
      end
   end

`ifndef SYNTHESIS
   // the divider never runs on a zero period
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK_DIV || state_ff == ST_DER_DIV) |-> dt_ff != 16'd0)
      else $error("divider started with zero period");

   // integral stays inside its bound after the clamp step
   a_integ_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INTEG_CLAMP) |=>
         (49'(integral_ff) <= bound_pos && 49'(integral_ff) >= -bound_pos))
      else $error("integral outside bound");

   // a computed drive lies between the output limits
   a_drive_limits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLAMP && out_free) |=>
         (rsp_drive_ff >= lim_lo && rsp_drive_ff <= lim_hi && rsp_ok_ff))
      else $error("drive outside limits");

   // a clear leaves zero state behind
   a_clear_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECODE && req_code_ff == REQ_CLEAR && out_free) |=>
         (integral_ff == '0 && last_err_ff == '0 && rsp_valid_ff))
      else $error("clear did not zero state");
`endif

endmodule
